### rtl/pcp_pkg.sv
// Shared types and constants of the point-capsule pushout block.
// No dependencies; used by the controller, datapath and top level.
package pcp_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // register select is byte address bit 2
    localparam logic REG_COUNT  = 1'b0;
    localparam logic REG_RADIUS = 1'b1;

    localparam logic [6:0]  COUNT_RST  = 7'd0;
    localparam logic [19:0] RADIUS_RST = 20'd12452;

    localparam int ROW_W   = 192;
    localparam int ACC_W   = 69;
    localparam int DEN_W   = 67;
    localparam int NUMER_W = 50;
    localparam int RAD_W   = 56;
    localparam int ROOT_W  = 28;

    localparam logic [5:0]  H_STEPS  = 6'd16;
    localparam logic [5:0]  M_STEPS  = 6'd50;
    localparam logic [4:0]  SQ_STEPS = 5'd28;
    localparam logic [16:0] H_ONE    = 17'd65536;

    typedef enum logic [2:0] {
        PH_DEN  = 3'd0,
        PH_NUM  = 3'd1,
        PH_Q    = 3'd2,
        PH_DIST = 3'd3,
        PH_MAG  = 3'd4
    } phase_t;

    typedef struct packed {
        logic       init;
        logic       row;
        logic       mul;
        logic       acc;
        logic       pend;
        logic       hset;
        logic       wb;
        logic       out_load;
        phase_t     phase;
        logic [1:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic h_div;
        logic slot_hit;
        logic dist_zero;
        logic div_busy;
        logic sqrt_busy;
    } dp_stat_t;

    function automatic logic [31:0] sat32(input logic signed [51:0] v);
        logic [31:0] r;
        if (v > 52'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -52'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### rtl/pcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pcp_datapath.sv
// Datapath: shared multiplier and accumulator, iterative divider and square root.
// Depends on pcp_pkg; driven by pcp_ctrl through dp_cmd_t.
module pcp_datapath
    import pcp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           st,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic [19:0]        radius,
    input  logic [ROW_W-1:0]   row,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               hit
);

    logic signed [31:0] p_reg [3];
    logic signed [31:0] a_reg [3];
    logic signed [31:0] q_reg [3];
    logic signed [32:0] ba_reg [3];
    logic signed [32:0] pa_reg [3];
    logic signed [32:0] d_reg [3];
    logic signed [65:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [16:0]        h_reg;
    logic [39:0]        r2_reg;
    logic               hit_reg;
    logic [31:0]        ox_reg;
    logic [31:0]        oy_reg;
    logic [31:0]        oz_reg;
    logic               ohit_reg;

    logic [DEN_W-1:0]   dv_r_reg;
    logic [DEN_W-1:0]   dv_d_reg;
    logic [NUMER_W-1:0] dv_q_reg;
    logic [5:0]         dv_cnt_reg;
    logic               dv_busy_reg;

    logic [RAD_W-1:0]   sq_rad_reg;
    logic [29:0]        sq_rem_reg;
    logic [ROOT_W-1:0]  sq_root_reg;
    logic [4:0]         sq_cnt_reg;
    logic               sq_busy_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [32:0] d_sel;
    logic [32:0]        d_mag;
    logic signed [31:0] a_sel;
    logic signed [31:0] p_sel;
    logic signed [31:0] q_sel;
    logic signed [65:0] qround;
    logic [33:0]        qsum;
    logic [31:0]        q_new;
    logic [32:0]        d_new;
    logic [51:0]        wb_sum;
    logic               acc_pos;
    logic               acc_ge_den;
    logic               slot_hit;
    logic [NUMER_W-1:0] nume;

    logic               dv_start;
    logic [DEN_W-1:0]   dv_r_init;
    logic [DEN_W-1:0]   dv_d_init;
    logic [NUMER_W-1:0] dv_q_init;
    logic [5:0]         dv_steps;
    logic [DEN_W:0]     dv_trial;
    logic               dv_ge;

    logic               sq_start;
    logic [31:0]        sq_rem2;
    logic [31:0]        sq_trial;
    logic               sq_ge;

    always_comb
    begin
        d_sel = d_reg[cmd.k];
        a_sel = a_reg[cmd.k];
        p_sel = p_reg[cmd.k];
        q_sel = q_reg[cmd.k];
        d_mag = d_sel[32] ? 33'(-d_sel) : d_sel;
        case (cmd.phase)
            PH_DEN:
            begin
                mul_a = ba_reg[cmd.k];
                mul_b = ba_reg[cmd.k];
            end
            PH_NUM:
            begin
                mul_a = pa_reg[cmd.k];
                mul_b = ba_reg[cmd.k];
            end
            PH_Q:
            begin
                mul_a = ba_reg[cmd.k];
                mul_b = $signed({16'd0, h_reg});
            end
            PH_DIST:
            begin
                mul_a = d_sel;
                mul_b = d_sel;
            end
            PH_MAG:
            begin
                // |d| is below the radius on this path
                mul_a = $signed({13'd0, radius});
                mul_b = $signed(d_mag);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // axis point rounded half up, and offset from it
    assign qround = (prod_reg + 66'sd32768) >>> 16;
    assign qsum   = {{2{a_sel[31]}}, a_sel} + qround[33:0];
    assign q_new  = qsum[31:0];
    assign d_new  = {p_sel[31], p_sel} - {q_new[31], q_new};

    assign wb_sum = d_sel[32] ? ({{20{q_sel[31]}}, q_sel} - {2'd0, dv_q_reg})
                              : ({{20{q_sel[31]}}, q_sel} + {2'd0, dv_q_reg});

    assign acc_pos    = !acc_reg[ACC_W-1] && (acc_reg != '0);
    assign acc_ge_den = $unsigned(acc_reg) >= {2'd0, den_reg};
    assign slot_hit   = $unsigned(acc_reg) < {29'd0, r2_reg};
    assign nume       = {prod_reg[41:0], 8'd0} + {23'd0, sq_root_reg[ROOT_W-1:1]};

    always_comb
    begin
        st.h_div     = acc_pos && !acc_ge_den;
        st.slot_hit  = slot_hit;
        st.dist_zero = (acc_reg == '0);
        st.div_busy  = dv_busy_reg;
        st.sqrt_busy = sq_busy_reg;
    end

    always_comb
    begin
        dv_start  = 1'b0;
        dv_r_init = '0;
        dv_d_init = '0;
        dv_q_init = '0;
        dv_steps  = '0;
        if (cmd.pend && cmd.phase == PH_NUM && acc_pos && !acc_ge_den)
        begin
            // fraction h = num * 2^16 / den, num < den
            dv_start  = 1'b1;
            dv_r_init = acc_reg[DEN_W-1:0];
            dv_d_init = den_reg;
            dv_steps  = H_STEPS;
        end
        else if (cmd.acc && cmd.phase == PH_MAG)
        begin
            dv_start  = 1'b1;
            dv_q_init = nume;
            dv_d_init = {39'd0, sq_root_reg};
            dv_steps  = M_STEPS;
        end
    end

    assign dv_trial = {dv_r_reg, dv_q_reg[NUMER_W-1]};
    assign dv_ge    = dv_trial >= {1'b0, dv_d_reg};

    assign sq_start = cmd.pend && cmd.phase == PH_DIST && slot_hit && (acc_reg != '0);
    assign sq_rem2  = {sq_rem_reg, sq_rad_reg[RAD_W-1 -: 2]};
    assign sq_trial = {2'd0, sq_root_reg, 2'b01};
    assign sq_ge    = sq_rem2 >= sq_trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
            dv_cnt_reg  <= '0;
            sq_busy_reg <= 1'b0;
            sq_cnt_reg  <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.init)
            begin
                hit_reg <= 1'b0;
            end
            else if (cmd.pend && cmd.phase == PH_DIST && slot_hit)
            begin
                hit_reg <= 1'b1;
            end

            if (dv_start)
            begin
                dv_busy_reg <= 1'b1;
                dv_cnt_reg  <= dv_steps;
            end
            else if (dv_busy_reg)
            begin
                dv_busy_reg <= (dv_cnt_reg != 6'd1);
                dv_cnt_reg  <= dv_cnt_reg - 6'd1;
            end

            if (sq_start)
            begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= SQ_STEPS;
            end
            else if (sq_busy_reg)
            begin
                sq_busy_reg <= (sq_cnt_reg != 5'd1);
                sq_cnt_reg  <= sq_cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg <= 40'(radius) * 40'(radius);

        if (dv_start)
        begin
            dv_r_reg <= dv_r_init;
            dv_d_reg <= dv_d_init;
            dv_q_reg <= dv_q_init;
        end
        else if (dv_busy_reg)
        begin
            dv_r_reg <= dv_ge ? DEN_W'(dv_trial - {1'b0, dv_d_reg}) : DEN_W'(dv_trial);
            dv_q_reg <= {dv_q_reg[NUMER_W-2:0], dv_ge};
        end

        if (sq_start)
        begin
            sq_rad_reg  <= {acc_reg[39:0], 16'd0};
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (sq_busy_reg)
        begin
            sq_rad_reg  <= {sq_rad_reg[RAD_W-3:0], 2'b00};
            sq_rem_reg  <= sq_ge ? 30'(sq_rem2 - sq_trial) : 30'(sq_rem2);
            sq_root_reg <= {sq_root_reg[ROOT_W-2:0], sq_ge};
        end

        if (cmd.init)
        begin
            p_reg[0] <= point_x;
            p_reg[1] <= point_y;
            p_reg[2] <= point_z;
        end

        if (cmd.row)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i]  <= row[32*i +: 32];
                ba_reg[i] <= {row[96+32*i+31], row[96+32*i +: 32]}
                           - {row[32*i+31], row[32*i +: 32]};
                pa_reg[i] <= {p_reg[i][31], p_reg[i]} - {row[32*i+31], row[32*i +: 32]};
            end
            acc_reg <= '0;
        end

        if (cmd.mul)
        begin
            prod_reg <= mul_a * mul_b;
        end

        if (cmd.acc)
        begin
            case (cmd.phase)
                PH_DEN, PH_NUM, PH_DIST:
                begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                end
                PH_Q:
                begin
                    q_reg[cmd.k] <= q_new;
                    d_reg[cmd.k] <= d_new;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.pend)
        begin
            case (cmd.phase)
                PH_DEN:
                begin
                    den_reg <= acc_reg[DEN_W-1:0];
                    acc_reg <= '0;
                end
                PH_NUM:
                begin
                    acc_reg <= '0;
                    if (!acc_pos)
                    begin
                        h_reg <= '0;
                    end
                    else if (acc_ge_den)
                    begin
                        h_reg <= H_ONE;
                    end
                end
                PH_DIST:
                begin
                    // point on the axis lands on the axis point
                    if (slot_hit && acc_reg == '0)
                    begin
                        p_reg <= q_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.hset)
        begin
            h_reg <= {1'b0, dv_q_reg[15:0]};
        end

        if (cmd.wb)
        begin
            p_reg[cmd.k] <= sat32($signed(wb_sum));
        end

        if (cmd.out_load)
        begin
            ox_reg   <= p_reg[0];
            oy_reg   <= p_reg[1];
            oz_reg   <= p_reg[2];
            ohit_reg <= hit_reg;
        end
    end

    assign out_x = ox_reg;
    assign out_y = oy_reg;
    assign out_z = oz_reg;
    assign hit   = ohit_reg;

endmodule

### rtl/pcp_ctrl.sv
// Controller: walks the slots of a query and sequences the datapath.
// Depends on pcp_pkg; drives pcp_datapath and the table read port.
module pcp_ctrl
    import pcp_pkg::*;
#(
    parameter int MAX_CAPSULES = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_query,
    output logic     in_ready,
    input  logic     out_ready,
    output logic     out_valid,
    input  logic [$clog2(MAX_CAPSULES+1)-1:0] count_lim,
    input  dp_stat_t st,
    output dp_cmd_t  cmd,
    output logic     rd_en,
    output logic [(MAX_CAPSULES > 1 ? $clog2(MAX_CAPSULES) : 1)-1:0] rd_addr
);

    localparam int AW = MAX_CAPSULES > 1 ? $clog2(MAX_CAPSULES) : 1;
    localparam int CW = $clog2(MAX_CAPSULES + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHECK = 10'b0000000010,
        S_ROW   = 10'b0000000100,
        S_MUL   = 10'b0000001000,
        S_ACC   = 10'b0000010000,
        S_PEND  = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_SQRT  = 10'b0010000000,
        S_WB    = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [1:0]    k_reg, k_next;
    logic [CW-1:0] slot_reg, slot_next;
    logic          out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        k_next       = k_reg;
        slot_next    = slot_reg;
        cmd          = '0;
        cmd.phase    = phase_reg;
        cmd.k        = k_reg;
        rd_en        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_query)
                begin
                    cmd.init   = 1'b1;
                    slot_next  = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (slot_reg == count_lim)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                cmd.row    = 1'b1;
                phase_next = PH_DEN;
                k_next     = 2'd0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (phase_reg == PH_MAG)
                begin
                    state_next = S_DIV;
                end
                else if (k_reg == 2'd2)
                begin
                    k_next     = 2'd0;
                    state_next = S_PEND;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_PEND:
            begin
                cmd.pend = 1'b1;
                case (phase_reg)
                    PH_DEN:
                    begin
                        phase_next = PH_NUM;
                        state_next = S_MUL;
                    end
                    PH_NUM:
                    begin
                        if (st.h_div)
                        begin
                            state_next = S_DIV;
                        end
                        else
                        begin
                            phase_next = PH_Q;
                            state_next = S_MUL;
                        end
                    end
                    PH_Q:
                    begin
                        phase_next = PH_DIST;
                        state_next = S_MUL;
                    end
                    PH_DIST:
                    begin
                        if (st.slot_hit && !st.dist_zero)
                        begin
                            state_next = S_SQRT;
                        end
                        else
                        begin
                            slot_next  = slot_reg + CW'(1);
                            state_next = S_CHECK;
                        end
                    end
                    default:
                    begin
                        state_next = S_CHECK;
                    end
                endcase
            end
            S_DIV:
            begin
                if (!st.div_busy)
                begin
                    if (phase_reg == PH_NUM)
                    begin
                        cmd.hset   = 1'b1;
                        phase_next = PH_Q;
                        k_next     = 2'd0;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_WB;
                    end
                end
            end
            S_SQRT:
            begin
                if (!st.sqrt_busy)
                begin
                    phase_next = PH_MAG;
                    k_next     = 2'd0;
                    state_next = S_MUL;
                end
            end
            S_WB:
            begin
                cmd.wb = 1'b1;
                if (k_reg == 2'd2)
                begin
                    slot_next  = slot_reg + CW'(1);
                    state_next = S_CHECK;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_DEN;
            k_reg         <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            k_reg         <= k_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign rd_addr   = slot_reg[AW-1:0];

endmodule

### rtl/point_capsule_collision_pushout_core.sv
// Point-capsule pushout: load requests are taken back to back while no query is in progress.
// A query raises out_valid once every slot has been walked; a slot whose h is not clamped
// adds the 16-step division for h, and each push adds a 28-step square root and three
// 50-step divisions, all on the shared units.
// One query at a time; input is ready again once the result moves to the output register.
// Reset clears control and config (count 0, radius 12452); the table is not cleared.
module point_capsule_collision_pushout_core
    import pcp_pkg::*;
#(
    parameter int MAX_CAPSULES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [5:0]         slot,
    input  logic signed [31:0] end_a_x,
    input  logic signed [31:0] end_a_y,
    input  logic signed [31:0] end_a_z,
    input  logic signed [31:0] end_b_x,
    input  logic signed [31:0] end_b_y,
    input  logic signed [31:0] end_b_z,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               hit
);

    localparam int AW = MAX_CAPSULES > 1 ? $clog2(MAX_CAPSULES) : 1;
    localparam int CW = $clog2(MAX_CAPSULES + 1);

    logic [6:0]       count_reg;
    logic [19:0]      radius_reg;
    logic [CW-1:0]    count_lim;
    logic             ram_we;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [ROW_W-1:0] rd_row;
    dp_cmd_t          cmd;
    dp_stat_t         st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= COUNT_RST;
            radius_reg <= RADIUS_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_RADIUS)
                radius_reg <= pwdata[19:0];
            else
                count_reg <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RADIUS) ? {12'd0, radius_reg} : {25'd0, count_reg};

    assign count_lim = (32'(count_reg) > MAX_CAPSULES) ? CW'(MAX_CAPSULES) : CW'(count_reg);

    // loads to slots beyond the table are dropped
    assign ram_we = in_valid && in_ready && (opcode == OP_LOAD) && (32'(slot) < MAX_CAPSULES);

    pcp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_CAPSULES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(slot)),
        .wdata ({end_b_z, end_b_y, end_b_x, end_a_z, end_a_y, end_a_x}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_row)
    );

    pcp_ctrl #(
        .MAX_CAPSULES (MAX_CAPSULES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_query  (opcode == OP_QUERY),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .count_lim (count_lim),
        .st        (st),
        .cmd       (cmd),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    pcp_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .st      (st),
        .point_x (point_x),
        .point_y (point_y),
        .point_z (point_z),
        .radius  (radius_reg),
        .row     (rd_row),
        .out_x   (out_x),
        .out_y   (out_y),
        .out_z   (out_z),
        .hit     (hit)
    );

`ifndef NO_ASSERTIONS
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode == OP_QUERY) |=> !in_ready)
        else $error("request taken while a query is in progress");

    a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result register load not shown on output");

    a_rd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (!in_ready && !ram_we))
        else $error("table read outside a query");

    a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(st.div_busy && st.sqrt_busy))
        else $error("divider and square root active together");
`endif

endmodule

### tb/tb_point_capsule_collision_pushout_core.sv
// Self-checking testbench of the point-capsule pushout core: loads capsule slots,
// queries points, and checks each result against a cycle-free predictor.
// Depends on rtl/pcp_pkg.sv and rtl/point_capsule_collision_pushout_core.sv.
`timescale 1ns / 100ps

module tb_point_capsule_collision_pushout_core;
    import pcp_pkg::*;

    localparam int N_SLOTS   = 64;
    localparam int WDOG_MAX  = 60000;
    localparam int HOLD_LEN  = 3000;
    localparam int SETTLE    = 30;
    localparam int LOC_RANGE = 262144;  // +-4.0 in Q16.16

    typedef struct {
        logic               op;
        logic [5:0]         sl;
        logic signed [31:0] ax, ay, az, bx, by, bz, px, py, pz;
    } req_t;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic               h;
    } pos_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic opcode = OP_LOAD;
    logic [5:0] slot = '0;
    logic signed [31:0] end_a_x = '0, end_a_y = '0, end_a_z = '0;
    logic signed [31:0] end_b_x = '0, end_b_y = '0, end_b_z = '0;
    logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] out_x, out_y, out_z;
    logic hit;

    req_t pending_q[$];
    pos_t resolved_q[$];
    req_t cur_req;

    // shadow of the block's table and registers
    int         cap_tab [N_SLOTS][6];
    logic [6:0]  cap_cnt;
    logic [19:0] cap_rad;

    int err_cnt = 0;
    int sent_cnt = 0;
    int got_cnt = 0;
    int idle_cyc = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    point_capsule_collision_pushout_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .slot(slot),
        .end_a_x(end_a_x), .end_a_y(end_a_y), .end_a_z(end_a_z),
        .end_b_x(end_b_x), .end_b_y(end_b_y), .end_b_z(end_b_z),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .hit(hit)
    );

    always #10 clk = ~clk;

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // one capsule against the running point; true when the point is pushed
    function automatic bit push_capsule(inout longint p [3], input int s);
        longint a [3], ba [3], q [3], d [3];
        logic signed [127:0] num, den, dist2, r2, bw, pw, dw;
        longint h, o;
        logic [63:0] len, m, dm;
        num = 0;
        den = 0;
        dist2 = 0;
        h = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = cap_tab[s][i];
            ba[i] = longint'(cap_tab[s][i+3]) - a[i];
            bw = ba[i];
            pw = p[i] - a[i];
            den += bw * bw;
            num += pw * bw;
        end
        if (num > 0)
        begin
            if (num >= den)
                h = 65536;
            else
                for (int i = 0; i < 16; i++)
                begin
                    num = num <<< 1;
                    h = h << 1;
                    if (num >= den)
                    begin
                        num -= den;
                        h = h | 1;
                    end
                end
        end
        for (int i = 0; i < 3; i++)
        begin
            q[i] = a[i] + ((ba[i] * h + 32768) >>> 16);
            d[i] = p[i] - q[i];
            dw = d[i];
            dist2 += dw * dw;
        end
        r2 = $signed({108'd0, cap_rad}) * $signed({108'd0, cap_rad});
        if (dist2 >= r2)
            return 1'b0;
        if (dist2 == 0)
        begin
            for (int i = 0; i < 3; i++) p[i] = q[i];
            return 1'b1;
        end
        len = isqrt(dist2[63:0] << 16);
        for (int i = 0; i < 3; i++)
        begin
            dm = (d[i] < 0) ? -d[i] : d[i];
            m = 64'(cap_rad) * dm * 256;
            o = longint'((m + len / 2) / len);
            p[i] = clamp32(d[i] < 0 ? q[i] - o : q[i] + o);
        end
        return 1'b1;
    endfunction

    // apply one accepted request to the shadow state; queue the result of a query
    task automatic resolve_request(input req_t r);
        longint p [3];
        int n;
        pos_t e;
        if (r.op == OP_LOAD)
        begin
            cap_tab[r.sl] = '{r.ax, r.ay, r.az, r.bx, r.by, r.bz};
            return;
        end
        p = '{r.px, r.py, r.pz};
        n = (cap_cnt > N_SLOTS) ? N_SLOTS : cap_cnt;
        e.h = 1'b0;
        for (int s = 0; s < n; s++)
            if (push_capsule(p, s)) e.h = 1'b1;
        e.x = p[0][31:0];
        e.y = p[1][31:0];
        e.z = p[2][31:0];
        resolved_q.insert(resolved_q.size(), e);
    endtask

    task automatic add_req(input req_t r);
        pending_q.insert(pending_q.size(), r);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch on %s at result %0d: got %h, want %h", what, got_cnt, got, want);
        err_cnt++;
    endtask

    task automatic reg_write(input logic sel, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {sel, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_COUNT)
            cap_cnt = val[6:0];
        else
            cap_rad = val[19:0];
    endtask

    function automatic logic signed [31:0] loc();
        return $signed($urandom_range(0, 2 * LOC_RANGE)) - LOC_RANGE;
    endfunction

    function automatic req_t load_req(input int s, input bit wide);
        req_t r;
        r.op = OP_LOAD;
        r.sl = s[5:0];
        r.px = $urandom; r.py = $urandom; r.pz = $urandom;
        if (wide)
        begin
            r.ax = $urandom; r.ay = $urandom; r.az = $urandom;
            r.bx = $urandom; r.by = $urandom; r.bz = $urandom;
        end
        else
        begin
            r.ax = loc(); r.ay = loc(); r.az = loc();
            r.bx = loc(); r.by = loc(); r.bz = loc();
        end
        return r;
    endfunction

    function automatic req_t query_req(input bit wide);
        req_t r;
        r.op = OP_QUERY;
        r.sl = 6'($urandom);
        r.ax = $urandom; r.ay = $urandom; r.az = $urandom;
        r.bx = $urandom; r.by = $urandom; r.bz = $urandom;
        if (wide)
        begin
            r.px = $urandom; r.py = $urandom; r.pz = $urandom;
        end
        else
        begin
            r.px = loc(); r.py = loc(); r.pz = loc();
        end
        return r;
    endfunction

    function automatic req_t mk(input logic op, input int s,
                                input logic signed [31:0] ax, ay, az, bx, by, bz, px, py, pz);
        req_t r;
        r = '{op, s[5:0], ax, ay, az, bx, by, bz, px, py, pz};
        return r;
    endfunction

    // sampled away from the rising edge so the driver's updates have settled
    task automatic drain();
        while (pending_q.size() != 0 || in_valid || resolved_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // request driver
    always @(posedge clk)
    begin
        bit take, quiet;
        req_t nx;
        if (rst_n)
        begin
            take = !in_valid;
            if (in_valid && in_ready)
            begin
                resolve_request(cur_req);
                sent_cnt++;
                take = 1'b1;
            end
            quiet = (sent_cnt >= 200 && sent_cnt < 300);
            if (take)
            begin
                if (pending_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 15))
                begin
                    nx = pending_q.pop_front();
                    cur_req <= nx;
                    in_valid <= 1'b1;
                    opcode <= nx.op;
                    slot <= nx.sl;
                    end_a_x <= nx.ax; end_a_y <= nx.ay; end_a_z <= nx.az;
                    end_b_x <= nx.bx; end_b_y <= nx.by; end_b_z <= nx.bz;
                    point_x <= nx.px; point_y <= nx.py; point_z <= nx.pz;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        pos_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (resolved_q.size() == 0)
                begin
                    $display("unexpected result %h %h %h hit %b", out_x, out_y, out_z, hit);
                    err_cnt++;
                end
                else
                begin
                    e = resolved_q.pop_front();
                    if (out_x !== e.x) report("out_x", out_x, e.x);
                    if (out_y !== e.y) report("out_y", out_y, e.y);
                    if (out_z !== e.z) report("out_z", out_z, e.z);
                    if (hit !== e.h) report("hit", 32'(hit), 32'(e.h));
                end
                got_cnt++;
            end
            // one long hold-off so the block backs up into its input
            if (!hold_done && got_cnt == 30)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (got_cnt >= 100 && got_cnt < 180)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 15);
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WDOG_MAX)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int cnt_sel, n_items, k;
        for (int s = 0; s < N_SLOTS; s++) cap_tab[s] = '{0, 0, 0, 0, 0, 0};
        cap_cnt = COUNT_RST;
        cap_rad = RADIUS_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // fill every slot before any count above zero is used
        reg_write(REG_COUNT, 32'd0);
        for (int s = 0; s < N_SLOTS; s++) add_req(load_req(s, 1'b0));
        for (int i = 0; i < 3; i++) add_req(query_req(1'b1));
        drain();

        // directed: zero-length segment, point on the axis, extreme coordinates
        reg_write(REG_COUNT, 32'd3);
        reg_write(REG_RADIUS, 32'd65536);
        add_req(mk(OP_LOAD, 0, 65536, 0, 0, 65536, 0, 0, 0, 0, 0));
        add_req(mk(OP_LOAD, 1, 0, 0, 0, 0, 0, 262144, 0, 0, 0));
        add_req(mk(OP_LOAD, 2, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                   32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0));
        add_req(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65536));
        add_req(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 65536 + 100, 0, 0));
        add_req(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 65536, 0, 0));
        add_req(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0,
                   32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
        add_req(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0,
                   32'sh80000000, 32'sh80000000, 32'sh80000000));
        add_req(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0,
                   32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        add_req(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 100, 50, 131072));
        add_req(mk(OP_LOAD, 63, 32'sh80000000, 32'sh7fffffff, 0,
                   32'sh7fffffff, 32'sh80000000, -1, 0, 0, 0));
        add_req(mk(OP_LOAD, 62, 5, 5, 5, 5, 5, 5, 0, 0, 0));
        drain();

        // zero radius: nothing can be hit
        reg_write(REG_RADIUS, 32'd0);
        reg_write(REG_COUNT, 32'd4);
        for (int i = 0; i < 4; i++) add_req(query_req(1'b0));
        drain();

        // widest radius over the whole table
        reg_write(REG_RADIUS, 32'hfffff);
        reg_write(REG_COUNT, 32'd64);
        for (int i = 0; i < 3; i++) add_req(query_req(1'b0));
        add_req(query_req(1'b1));
        drain();

        // count above the table saturates
        reg_write(REG_COUNT, 32'd127);
        reg_write(REG_RADIUS, 32'd20000);
        for (int i = 0; i < 3; i++) add_req(query_req(1'b0));
        drain();

        // random phases, mostly few slots and local coordinates
        for (int ph = 0; ph < 12; ph++)
        begin
            cnt_sel = $urandom_range(1, 6);
            reg_write(REG_COUNT, cnt_sel);
            reg_write(REG_RADIUS, (ph == 5) ? 32'hfffff : $urandom_range(8000, 200000));
            n_items = 40;
            for (int i = 0; i < n_items; i++)
            begin
                k = $urandom_range(0, 99);
                if (k < 20)
                    add_req(load_req($urandom_range(0, N_SLOTS - 1), 1'b0));
                else if (k < 25)
                    add_req(load_req($urandom_range(0, N_SLOTS - 1), 1'b1));
                else if (k < 30)
                    add_req(query_req(1'b1));
                else
                    add_req(query_req(1'b0));
            end
            drain();
        end

        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
